### sv/last_note_priority_list_core_assert.svh
// assertion macros used by the checker file of the note list core
// depends on nothing; expects clk and rst_n in the scope of each use
`ifndef LAST_NOTE_PRIORITY_LIST_CORE_ASSERT_SVH
`define LAST_NOTE_PRIORITY_LIST_CORE_ASSERT_SVH

// overlapping implication, checked outside reset
`define LNPL_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// implication into the next cycle, checked outside reset
`define LNPL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/lnpl_pkg.sv
// package of the note list core: sizes, opcodes and controller/datapath types
// depends on nothing
package lnpl_pkg;

  // sizes
  localparam int NOTE_KEYS  = 13;
  localparam int RING_DEPTH = 32;
  localparam int OP_W       = 2;
  localparam int NOTE_W     = 4;
  localparam int OUT_W      = 5;
  localparam int CNT_W      = $clog2(NOTE_KEYS + 1);
  localparam int PTR_W      = $clog2(RING_DEPTH);

  // opcodes
  localparam logic [OP_W-1:0] OP_PRESS   = 2'd0;
  localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;
  localparam logic [OP_W-1:0] OP_POP     = 2'd2;
  localparam logic [OP_W-1:0] OP_READ    = 2'd3;

  // held list read address selection
  localparam logic [1:0] RA_IDX  = 2'd0;
  localparam logic [1:0] RA_IDX1 = 2'd1;
  localparam logic [1:0] RA_OIDX = 2'd2;
  localparam logic [1:0] RA_LAST = 2'd3;

  // reply code for no note
  localparam logic signed [OUT_W-1:0] NO_NOTE = -5'sd1;

  // commands from controller to datapath
  typedef struct packed {
    logic       load_in;
    logic       idx_inc;
    logic [1:0] raddr_sel;
    logic       hwr_append;
    logic       hwr_shift;
    logic       total_inc;
    logic       total_dec;
    logic       ring_push;
    logic       ring_rd;
    logic       reply_from_list;
    logic       reply_from_ring;
    logic       out_load;
  } lnpl_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            note_ok;
    logic            oidx_ok;
    logic            match;
    logic            idx_at_end;
    logic            shift_more;
    logic            list_full;
    logic            ring_full;
    logic            ring_empty;
    logic            out_free;
  } lnpl_sts_t;

endpackage

### sv/lnpl_if.sv
// word channels of the note list core: key events in, results out
// depends on lnpl_pkg
interface lnpl_in_if import lnpl_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   opcode;
  logic [NOTE_W-1:0] note;
  logic [NOTE_W-1:0] order_index;

  modport source (output valid, opcode, note, order_index, input ready);
  modport sink (input valid, opcode, note, order_index, output ready);
endinterface

interface lnpl_out_if import lnpl_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] current_note;
  logic [CNT_W-1:0]        held_count;
  logic signed [OUT_W-1:0] reply_note;

  modport source (output valid, current_note, held_count, reply_note, input ready);
  modport sink (input valid, current_note, held_count, reply_note, output ready);
endinterface

### sv/lnpl_datapath.sv
// datapath of the note list core: held list registers, note-on ring memory,
// counters and the output register; depends on lnpl_pkg
module lnpl_datapath import lnpl_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  lnpl_cmd_t               cmd,
  output lnpl_sts_t               sts,
  input  logic [OP_W-1:0]         in_opcode,
  input  logic [NOTE_W-1:0]       in_note,
  input  logic [NOTE_W-1:0]       in_order_index,
  input  logic                    out_ready,
  output logic                    out_valid,
  output logic signed [OUT_W-1:0] out_current_note,
  output logic [CNT_W-1:0]        out_held_count,
  output logic signed [OUT_W-1:0] out_reply_note
);

  logic [OP_W-1:0]         op_r;
  logic [NOTE_W-1:0]       note_r;
  logic [NOTE_W-1:0]       oidx_r;
  logic [CNT_W-1:0]        idx_r;
  logic [CNT_W-1:0]        total_r;
  logic [PTR_W-1:0]        head_r;
  logic [PTR_W-1:0]        tail_r;
  logic signed [OUT_W-1:0] reply_r;
  logic [NOTE_W-1:0]       ring_q_r;
  logic                    out_valid_r;
  logic signed [OUT_W-1:0] cur_out_r;
  logic [CNT_W-1:0]        cnt_out_r;
  logic signed [OUT_W-1:0] reply_out_r;

  logic [NOTE_W-1:0] held_r [NOTE_KEYS];
  logic [NOTE_W-1:0] ring_mem [RING_DEPTH];

  logic [CNT_W-1:0]  idx_p1;
  logic [CNT_W-1:0]  raddr;
  logic [NOTE_W-1:0] held_rd;
  logic [CNT_W-1:0]  waddr;
  logic [NOTE_W-1:0] wdata;
  logic              hwr;
  logic [PTR_W-1:0]  tail_nxt;
  logic [PTR_W-1:0]  head_nxt;

  assign idx_p1 = idx_r + CNT_W'(1);

  // held list read port
  always_comb begin
    case (cmd.raddr_sel)
      RA_IDX:  raddr = idx_r;
      RA_IDX1: raddr = idx_p1;
      RA_OIDX: raddr = CNT_W'(oidx_r);
      RA_LAST: raddr = total_r - CNT_W'(1);
      default: raddr = idx_r;
    endcase
    held_rd = '0;
    for (int i = 0; i < NOTE_KEYS; i++) begin
      if (raddr == CNT_W'(i)) held_rd = held_r[i];
    end
  end

  // held list write port: append at the end or move one entry down
  assign hwr   = cmd.hwr_append | cmd.hwr_shift;
  assign waddr = cmd.hwr_append ? total_r : idx_r;
  assign wdata = cmd.hwr_append ? note_r : held_rd;

  always_ff @(posedge clk) begin
    for (int i = 0; i < NOTE_KEYS; i++) begin
      if (hwr && waddr == CNT_W'(i)) held_r[i] <= wdata;
    end
  end

  // ring pointers with wrap
  assign tail_nxt = (tail_r == PTR_W'(RING_DEPTH - 1)) ? '0 : tail_r + PTR_W'(1);
  assign head_nxt = (head_r == PTR_W'(RING_DEPTH - 1)) ? '0 : head_r + PTR_W'(1);

  // note-on ring memory, registered read
  always_ff @(posedge clk) begin
    if (cmd.ring_push) ring_mem[tail_r] <= note_r;
    if (cmd.ring_rd) ring_q_r <= ring_mem[head_r];
  end

  // event word capture
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_r   <= in_opcode;
      note_r <= in_note;
      oidx_r <= in_order_index;
    end
  end

  // scan index and reply
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      idx_r   <= '0;
      reply_r <= NO_NOTE;
    end else begin
      if (cmd.idx_inc) idx_r <= idx_p1;
      if (cmd.reply_from_list) reply_r <= $signed({1'b0, held_rd});
      else if (cmd.reply_from_ring) reply_r <= $signed({1'b0, ring_q_r});
    end
  end

  // list count and ring pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
      head_r  <= '0;
      tail_r  <= '0;
    end else begin
      if (cmd.total_inc) total_r <= total_r + CNT_W'(1);
      else if (cmd.total_dec) total_r <= total_r - CNT_W'(1);
      if (cmd.ring_push) tail_r <= tail_nxt;
      if (cmd.ring_rd) head_r <= head_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      cur_out_r   <= (total_r == '0) ? NO_NOTE : $signed({1'b0, held_rd});
      cnt_out_r   <= total_r;
      reply_out_r <= reply_r;
    end
  end

  // status to the controller
  always_comb begin
    sts.op         = op_r;
    sts.note_ok    = note_r < NOTE_W'(NOTE_KEYS);
    sts.oidx_ok    = CNT_W'(oidx_r) < total_r;
    sts.match      = held_rd == note_r;
    sts.idx_at_end = idx_r == total_r;
    sts.shift_more = idx_p1 < total_r;
    sts.list_full  = total_r == CNT_W'(NOTE_KEYS);
    sts.ring_full  = tail_nxt == head_r;
    sts.ring_empty = head_r == tail_r;
    sts.out_free   = !out_valid_r || out_ready;
  end

  assign out_valid        = out_valid_r;
  assign out_current_note = cur_out_r;
  assign out_held_count   = cnt_out_r;
  assign out_reply_note   = reply_out_r;

endmodule

### sv/lnpl_ctrl.sv
// controller of the note list core: sequences search, shift, ring access and
// result hand-off; depends on lnpl_pkg
module lnpl_ctrl import lnpl_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  lnpl_sts_t sts,
  output lnpl_cmd_t cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DISP  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_SHIFT = 3'd3;
  localparam logic [2:0] S_POPW  = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  assign in_ready = state_r == S_IDLE;

  // next state and commands
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_DISP;
        end
      end
      S_DISP: begin
        case (sts.op)
          OP_PRESS: begin
            if (sts.note_ok) begin
              cmd.ring_push = !sts.ring_full;
              state_nxt     = S_SCAN;
            end else begin
              state_nxt = S_DONE;
            end
          end
          OP_RELEASE: begin
            state_nxt = sts.note_ok ? S_SCAN : S_DONE;
          end
          OP_POP: begin
            if (!sts.ring_empty) begin
              cmd.ring_rd = 1'b1;
              state_nxt   = S_POPW;
            end else begin
              state_nxt = S_DONE;
            end
          end
          default: begin
            cmd.raddr_sel       = RA_OIDX;
            cmd.reply_from_list = sts.oidx_ok;
            state_nxt           = S_DONE;
          end
        endcase
      end
      // search the list one entry a cycle
      S_SCAN: begin
        cmd.raddr_sel = RA_IDX;
        if (sts.idx_at_end) begin
          if (sts.op == OP_PRESS && !sts.list_full) begin
            cmd.hwr_append = 1'b1;
            cmd.total_inc  = 1'b1;
          end
          state_nxt = S_DONE;
        end else if (sts.match) begin
          state_nxt = (sts.op == OP_PRESS) ? S_DONE : S_SHIFT;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      // close the gap left by a release
      S_SHIFT: begin
        cmd.raddr_sel = RA_IDX1;
        if (sts.shift_more) begin
          cmd.hwr_shift = 1'b1;
          cmd.idx_inc   = 1'b1;
        end else begin
          cmd.total_dec = 1'b1;
          state_nxt     = S_DONE;
        end
      end
      S_POPW: begin
        cmd.reply_from_ring = 1'b1;
        state_nxt           = S_DONE;
      end
      S_DONE: begin
        cmd.raddr_sel = RA_LAST;
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### sv/last_note_priority_list_core.sv
// top level of the note list core: joins controller and datapath to the channels
// depends on lnpl_pkg, lnpl_if, lnpl_ctrl and lnpl_datapath
//
// Last-note-priority key list for a monophonic keyboard. Each input word is
// a key event (press, release, pop of a queued note-on, or read of a held
// note by its press order) and each event returns one result word with the
// newest held note, the held count and a reply note (-1 for none). Events
// are handled one at a time: the next event is taken only after the result
// of the last one is loaded. A press or release of note 13 or above is
// ignored. A press or release searches the held list one entry at a time,
// and a release of a held note then shifts the later entries down to close
// the gap; a press of a note already held stops at its match. The held list
// has a single write port. A finished result sits in an output register, so
// the next event is taken while it waits; that event's result is held back
// until the waiting word has gone. The note-on ring is a 32-entry memory
// with one slot kept free; it needs no clearing after reset.
module last_note_priority_list_core import lnpl_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  lnpl_in_if.sink         in_ch,
  lnpl_out_if.source      out_ch
);

  lnpl_cmd_t cmd;
  lnpl_sts_t sts;
  logic      in_ready;

  assign in_ch.ready = in_ready;

  lnpl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lnpl_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_opcode        (in_ch.opcode),
    .in_note          (in_ch.note),
    .in_order_index   (in_ch.order_index),
    .out_ready        (out_ch.ready),
    .out_valid        (out_ch.valid),
    .out_current_note (out_ch.current_note),
    .out_held_count   (out_ch.held_count),
    .out_reply_note   (out_ch.reply_note)
  );

endmodule

### sv/lnpl_checker.sv
// port checker of the note list core, bound to the top level
// depends on lnpl_pkg and last_note_priority_list_core_assert.svh
`include "last_note_priority_list_core_assert.svh"

module lnpl_checker import lnpl_pkg::*; (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic signed [OUT_W-1:0] current_note,
  input logic [CNT_W-1:0]        held_count,
  input logic signed [OUT_W-1:0] reply_note
);

  // stalled result word holds
  `LNPL_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(current_note) && $stable(held_count) && $stable(reply_note), "result word changed while stalled")

  // one event at a time: busy right after an accept
  `LNPL_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "event taken while busy")

  // count never beyond the list size
  `LNPL_ASSERT_IMPL(a_count_range, out_valid, held_count <= CNT_W'(NOTE_KEYS), "held count out of range")

  // newest note is none exactly when the list is empty
  `LNPL_ASSERT_IMPL(a_cur_empty, out_valid, (held_count == '0) == (current_note == NO_NOTE), "current note disagrees with count")

  // reply is a note or none
  `LNPL_ASSERT_IMPL(a_reply_range, out_valid, reply_note >= NO_NOTE && reply_note < OUT_W'(NOTE_KEYS), "reply note out of range")

endmodule

bind last_note_priority_list_core lnpl_checker u_lnpl_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .current_note (out_ch.current_note),
  .held_count   (out_ch.held_count),
  .reply_note   (out_ch.reply_note)
);
